### sv/mnts_pkg.sv
// Package for the MIDI note to tone sequencer: widths, command codes, tone table, shared types.
package mnts_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int DELTA_W = 28;
    localparam int NOTE_W  = 7;
    localparam int TEMPO_W = 24;
    localparam int TPQ_W   = 15;
    localparam int DUR_W   = 32;
    localparam int FREQ_W  = 22;

    // Product of delta ticks and tempo, and the divider schedule (two bits per step)
    localparam int PROD_W      = DELTA_W + TEMPO_W;
    localparam int DIV_STEPS   = PROD_W / 2;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Reset values
    localparam logic [TPQ_W-1:0]   TPQ_RESET   = TPQ_W'(480);
    localparam logic [TEMPO_W-1:0] TEMPO_RESET = TEMPO_W'(500000);

    // Tone table format
    localparam int FREQ_FRAC_BITS = 8;
    localparam int NOTE_COUNT     = 128;
    localparam logic [63:0] FREQ_MAX = (64'd1 << FREQ_W) - 64'd1;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ON    = 2'd0,
        CMD_OFF   = 2'd1,
        CMD_TEMPO = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // Result of one time computation
    typedef struct packed {
        logic [DUR_W-1:0] t;
        logic             prod_nz;
    } t_arith_res;

    // Notes 120..131 in Hz, 16 fraction bits, rounded to nearest
    localparam logic [11:0][31:0] TOP_OCTAVE_Q16 = {
        32'd1035748353, 32'd977616265, 32'd922746880, 32'd870957077,
        32'd822074013,  32'd775934544, 32'd732384684, 32'd691279090,
        32'd652480562,  32'd615859655, 32'd581294109, 32'd548668578
    };

    typedef logic [NOTE_COUNT-1:0][FREQ_W-1:0] t_freq_rom;

    // Build the note frequency table at elaboration
    function automatic t_freq_rom build_freq_rom();
        t_freq_rom   rom;
        logic [63:0] v;
        int          idx;
        int          sh;
        rom = '0;
        for (int o = 0; o <= 10; o++) begin
            for (int s = 0; s < 12; s++) begin
                idx = o * 12 + s;
                if (idx < NOTE_COUNT) begin
                    sh = (16 - FREQ_FRAC_BITS) + (10 - o);
                    v  = 64'(TOP_OCTAVE_Q16[s[3:0]]);
                    if (sh > 0) begin
                        v = (v + (64'd1 << (sh - 1))) >> sh;
                    end
                    if (v > FREQ_MAX) begin
                        v = FREQ_MAX;
                    end
                    rom[idx[NOTE_W-1:0]] = v[FREQ_W-1:0];
                end
            end
        end
        return rom;
    endfunction

    localparam t_freq_rom FREQ_ROM = build_freq_rom();

endpackage

### sv/midi_note_to_tone_sequencer_unit.sv
// Top level of the MIDI note to tone sequencer: event decode, note state, output word register.
//
//   channel  direction  handshake              payload
//   input    in         i_valid / o_stall      i_command, i_delta_ticks, i_note, i_tempo_value
//   output   out        o_valid / i_stall      o_duration_us, o_frequency_q8, o_is_rest
//   config   in         i_cfg_wr_en            i_cfg_wr_data (ticks per quarter)
//
// A note event passes through accept, the multiply, 26 divide steps of two quotient
// bits each in the shared time unit, the result register and the decision state.
// Set-tempo and unused commands are taken in the idle state. o_stall is high while an event is at work.
// Reset is synchronous, active low; it restores tempo, division and note state at once.
// A finished word waits in the output register; a new word held back by i_stall holds
// the decision cycle until the register frees.
module midi_note_to_tone_sequencer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [mnts_pkg::CMD_W-1:0]    i_command,
    input  logic [mnts_pkg::DELTA_W-1:0]  i_delta_ticks,
    input  logic [mnts_pkg::NOTE_W-1:0]   i_note,
    input  logic [mnts_pkg::TEMPO_W-1:0]  i_tempo_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mnts_pkg::DUR_W-1:0]    o_duration_us,
    output logic [mnts_pkg::FREQ_W-1:0]   o_frequency_q8,
    output logic                          o_is_rest,
    input  logic                          i_cfg_wr_en,
    input  logic [mnts_pkg::TPQ_W-1:0]    i_cfg_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                            r_state, n_state;
    logic [mnts_pkg::TPQ_W-1:0]        r_tpq;
    logic [mnts_pkg::TEMPO_W-1:0]      r_tempo, n_tempo;
    logic [mnts_pkg::DUR_W-1:0]        r_acc, n_acc;
    logic                              r_rest_pend, n_rest_pend;
    logic                              r_last_off, n_last_off;
    logic [mnts_pkg::NOTE_W-1:0]       r_last_note, n_last_note;
    logic                              r_cur_off, n_cur_off;
    logic [mnts_pkg::NOTE_W-1:0]       r_cur_note, n_cur_note;
    mnts_pkg::t_arith_res              r_res, n_res;
    logic                              r_out_valid, n_out_valid;
    logic [mnts_pkg::DUR_W-1:0]        r_dur, n_dur;
    logic [mnts_pkg::FREQ_W-1:0]       r_freq, n_freq;
    logic                              r_is_rest, n_is_rest;

    logic                              w_accept;
    logic                              w_start;
    logic [mnts_pkg::TPQ_W-1:0]        w_divisor;
    logic                              w_arith_done;
    mnts_pkg::t_arith_res              w_arith_res;
    logic [mnts_pkg::DUR_W:0]          w_sum;
    logic [mnts_pkg::DUR_W-1:0]        w_sat_sum;
    logic                              w_tone;
    logic                              w_rest;
    logic                              w_blocked;
    logic                              w_fire;

    assign w_accept  = i_valid && !o_stall;
    assign w_start   = w_accept && (i_command == mnts_pkg::CMD_ON ||
                                    i_command == mnts_pkg::CMD_OFF);
    assign w_divisor = (r_tpq == '0) ? mnts_pkg::TPQ_W'(1) : r_tpq;

    mnts_arith u_arith (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_delta   (i_delta_ticks),
        .i_tempo   (r_tempo),
        .i_divisor (w_divisor),
        .o_done    (w_arith_done),
        .o_res     (w_arith_res)
    );

    // Saturating sum of the accumulated time and this event's time
    assign w_sum     = {1'b0, r_acc} + {1'b0, r_res.t};
    assign w_sat_sum = w_sum[mnts_pkg::DUR_W] ? '1 : w_sum[mnts_pkg::DUR_W-1:0];

    // Decide what the current event emits
    assign w_tone    = !r_last_off && (!r_cur_off || r_cur_note == r_last_note);
    assign w_rest    = r_last_off && !r_cur_off && r_rest_pend && r_res.prod_nz;
    assign w_blocked = r_out_valid && i_stall;
    assign w_fire    = (r_state == S_EMIT) && (w_tone || w_rest) && !w_blocked;

    // Sequencer and note state
    always_comb begin
        n_state     = r_state;
        n_tempo     = r_tempo;
        n_acc       = r_acc;
        n_rest_pend = r_rest_pend;
        n_last_off  = r_last_off;
        n_last_note = r_last_note;
        n_cur_off   = r_cur_off;
        n_cur_note  = r_cur_note;
        n_res       = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_command)
                        mnts_pkg::CMD_TEMPO: n_tempo = i_tempo_value;
                        mnts_pkg::CMD_ON, mnts_pkg::CMD_OFF: begin
                            n_cur_off  = (i_command == mnts_pkg::CMD_OFF);
                            n_cur_note = i_note;
                            n_state    = S_CALC;
                        end
                        default: ;
                    endcase
                end
            end
            S_CALC: begin
                if (w_arith_done) begin
                    n_res   = w_arith_res;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!((w_tone || w_rest) && w_blocked)) begin
                    n_state = S_IDLE;
                    if (!r_last_off) begin
                        if (w_tone) begin
                            n_acc       = '0;
                            n_rest_pend = r_rest_pend || r_cur_off;
                            n_last_off  = r_cur_off;
                            n_last_note = r_cur_note;
                        end else begin
                            n_acc = w_sat_sum;
                        end
                    end else if (!r_cur_off) begin
                        if (w_rest) begin
                            n_acc       = '0;
                            n_rest_pend = 1'b0;
                        end
                        n_last_off  = 1'b0;
                        n_last_note = r_cur_note;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Load the output word; drop it once taken
    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        n_dur       = r_dur;
        n_freq      = r_freq;
        n_is_rest   = r_is_rest;
        if (w_fire) begin
            n_out_valid = 1'b1;
            n_dur       = w_sat_sum;
            n_freq      = w_rest ? '0 : mnts_pkg::FREQ_ROM[r_last_note];
            n_is_rest   = w_rest;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tpq       <= mnts_pkg::TPQ_RESET;
            r_tempo     <= mnts_pkg::TEMPO_RESET;
            r_acc       <= '0;
            r_rest_pend <= 1'b0;
            r_last_off  <= 1'b0;
            r_last_note <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tpq       <= i_cfg_wr_en ? i_cfg_wr_data : r_tpq;
            r_tempo     <= n_tempo;
            r_acc       <= n_acc;
            r_rest_pend <= n_rest_pend;
            r_last_off  <= n_last_off;
            r_last_note <= n_last_note;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur_off  <= n_cur_off;
        r_cur_note <= n_cur_note;
        r_res      <= n_res;
        r_dur      <= n_dur;
        r_freq     <= n_freq;
        r_is_rest  <= n_is_rest;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_duration_us  = r_dur;
    assign o_frequency_q8 = r_freq;
    assign o_is_rest      = r_is_rest;

    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_arith_done |-> r_state == S_CALC)
        else $error("time unit finished outside the calc state");

    a_rest_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_rest) |-> o_frequency_q8 == '0)
        else $error("rest word carries a frequency");

    a_fire_clears_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_acc == '0 && o_valid && r_state == S_IDLE))
        else $error("emitted word did not clear the accumulated time");

    a_no_tone_and_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !(w_tone && w_rest))
        else $error("tone and rest decided together");

endmodule

### sv/mnts_arith.sv
// Time unit: delta ticks times tempo, then a two-bit-per-cycle restoring divide by the division.
module mnts_arith (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mnts_pkg::DELTA_W-1:0]  i_delta,
    input  logic [mnts_pkg::TEMPO_W-1:0]  i_tempo,
    input  logic [mnts_pkg::TPQ_W-1:0]    i_divisor,
    output logic                          o_done,
    output mnts_pkg::t_arith_res          o_res
);

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_MUL  = 3'b010,
        A_DIV  = 3'b100
    } t_astate;

    t_astate                            r_state, n_state;
    logic [mnts_pkg::DIV_CNT_W-1:0]     r_cnt, n_cnt;
    logic                               r_done, n_done;
    logic [mnts_pkg::DELTA_W-1:0]       r_delta, n_delta;
    logic [mnts_pkg::TEMPO_W-1:0]       r_tempo, n_tempo;
    logic [mnts_pkg::TPQ_W-1:0]         r_dsr, n_dsr;
    logic [mnts_pkg::PROD_W-1:0]        r_dvd, n_dvd;
    logic [mnts_pkg::TPQ_W-1:0]         r_rem, n_rem;
    logic                               r_nz, n_nz;

    logic [mnts_pkg::PROD_W-1:0]        w_prod;
    logic [mnts_pkg::TPQ_W:0]           w_x1, w_x2;
    logic [mnts_pkg::TPQ_W-1:0]         w_r1, w_r2;
    logic                               w_q1, w_q2;

    // Full product, combinational from the latched operands
    assign w_prod = mnts_pkg::PROD_W'(r_delta) * mnts_pkg::PROD_W'(r_tempo);

    // Two restoring compare-subtract stages
    always_comb begin
        w_x1 = {r_rem, r_dvd[mnts_pkg::PROD_W-1]};
        w_q1 = (w_x1 >= {1'b0, r_dsr});
        w_r1 = w_q1 ? mnts_pkg::TPQ_W'(w_x1 - {1'b0, r_dsr}) : w_x1[mnts_pkg::TPQ_W-1:0];
        w_x2 = {w_r1, r_dvd[mnts_pkg::PROD_W-2]};
        w_q2 = (w_x2 >= {1'b0, r_dsr});
        w_r2 = w_q2 ? mnts_pkg::TPQ_W'(w_x2 - {1'b0, r_dsr}) : w_x2[mnts_pkg::TPQ_W-1:0];
    end

    // Sequence: latch operands, multiply, divide
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_delta = r_delta;
        n_tempo = r_tempo;
        n_dsr   = r_dsr;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_nz    = r_nz;
        unique case (r_state)
            A_IDLE: begin
                if (i_start) begin
                    n_delta = i_delta;
                    n_tempo = i_tempo;
                    n_dsr   = i_divisor;
                    n_state = A_MUL;
                end
            end
            A_MUL: begin
                n_dvd   = w_prod;
                n_rem   = '0;
                n_nz    = (w_prod != '0);
                n_cnt   = '0;
                n_state = A_DIV;
            end
            A_DIV: begin
                n_dvd = {r_dvd[mnts_pkg::PROD_W-3:0], w_q1, w_q2};
                n_rem = w_r2;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == mnts_pkg::DIV_CNT_W'(mnts_pkg::DIV_STEPS - 1)) begin
                    n_done  = 1'b1;
                    n_state = A_IDLE;
                end
            end
            default: n_state = A_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_delta <= n_delta;
        r_tempo <= n_tempo;
        r_dsr   <= n_dsr;
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_nz    <= n_nz;
    end

    // Saturate the quotient to the duration width
    assign o_done        = r_done;
    assign o_res.t       = (r_dvd[mnts_pkg::PROD_W-1:mnts_pkg::DUR_W] != '0)
                           ? '1 : r_dvd[mnts_pkg::DUR_W-1:0];
    assign o_res.prod_nz = r_nz;

    a_done_leaves_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state) == A_DIV && r_state == A_IDLE)
        else $error("divide done without a finished divide");

    a_start_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == A_MUL) |=> (r_state == A_DIV && r_cnt == '0))
        else $error("multiply not followed by divide");

    a_rem_below_dsr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == A_DIV && r_dsr != '0) |-> r_rem < r_dsr)
        else $error("divide remainder out of range");

endmodule

### tb/tone_sequence_checker.sv
// Checker for the MIDI note to tone sequencer: watches both channels, predicts tone words, compares.
module tone_sequence_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [mnts_pkg::CMD_W-1:0]    i_command,
    input  logic [mnts_pkg::DELTA_W-1:0]  i_delta_ticks,
    input  logic [mnts_pkg::NOTE_W-1:0]   i_note,
    input  logic [mnts_pkg::TEMPO_W-1:0]  i_tempo_value,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [mnts_pkg::DUR_W-1:0]    i_duration_us,
    input  logic [mnts_pkg::FREQ_W-1:0]   i_frequency_q8,
    input  logic                          i_is_rest,
    input  logic                          i_cfg_wr_en,
    input  logic [mnts_pkg::TPQ_W-1:0]    i_cfg_wr_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_tone_count,
    output int                            o_rest_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PROD_BITS  = mnts_pkg::DELTA_W + mnts_pkg::TEMPO_W;
    localparam int PRINT_CAP  = 50;

    typedef struct {
        logic [mnts_pkg::DUR_W-1:0]  dur;
        logic [mnts_pkg::FREQ_W-1:0] freq;
        logic                        rest;
    } t_tone_word;

    // Frequencies of notes 120..131 in Hz with 16 fraction bits
    localparam logic [31:0] HIGH_OCTAVE_HZ [12] = '{
        32'd548668578, 32'd581294109, 32'd615859655, 32'd652480562,
        32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
        32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748353
    };

    t_tone_word                     tone_q[$];
    logic [mnts_pkg::TPQ_W-1:0]     division;
    logic [mnts_pkg::TEMPO_W-1:0]   cur_tempo;
    logic [mnts_pkg::DUR_W-1:0]     held_us;
    logic                           rest_armed;
    logic                           prev_off;
    logic [mnts_pkg::NOTE_W-1:0]    prev_note;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_tone_count = 0;
        o_rest_count = 0;
    end

    // Scale a top-octave entry down to the note's octave, round half up, clip
    function automatic logic [mnts_pkg::FREQ_W-1:0] tone_q8(logic [mnts_pkg::NOTE_W-1:0] n);
        int          octave;
        int          sh;
        logic [63:0] v;
        octave = int'(n) / 12;
        sh     = (16 - mnts_pkg::FREQ_FRAC_BITS) + (10 - octave);
        v      = 64'(HIGH_OCTAVE_HZ[int'(n) % 12]);
        if (sh > 0) begin
            v = (v + (64'd1 << (sh - 1))) >> sh;
        end
        if (v > 64'h3F_FFFF) begin
            v = 64'h3F_FFFF;
        end
        return v[mnts_pkg::FREQ_W-1:0];
    endfunction

    function automatic logic [mnts_pkg::DUR_W-1:0] add_clip(logic [mnts_pkg::DUR_W-1:0] a,
                                                            logic [mnts_pkg::DUR_W-1:0] b);
        logic [mnts_pkg::DUR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[mnts_pkg::DUR_W] ? '1 : s[mnts_pkg::DUR_W-1:0];
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (o_fail_count < PRINT_CAP) begin
            $display("ERROR %0t ns: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        end
        o_fail_count++;
    endtask

    // Compare one delivered tone word against the oldest prediction
    task automatic check_word();
        t_tone_word want;
        if (tone_q.size() == 0) begin
            flag_mismatch("unexpected word, duration", i_duration_us, '0);
        end else begin
            want = tone_q.pop_front();
            if (i_duration_us !== want.dur) begin
                flag_mismatch("duration_us", i_duration_us, want.dur);
            end
            if (i_frequency_q8 !== want.freq) begin
                flag_mismatch("frequency_q8", 32'(i_frequency_q8), 32'(want.freq));
            end
            if (i_is_rest !== want.rest) begin
                flag_mismatch("is_rest", 32'(i_is_rest), 32'(want.rest));
            end
            if (want.rest) begin
                o_rest_count++;
            end else begin
                o_tone_count++;
            end
        end
    endtask

    // Advance the note state by one event and queue the word it produces, if any
    task automatic predict_event();
        mnts_pkg::t_cmd             cmd;
        logic                       is_off;
        logic [PROD_BITS-1:0]       prod;
        logic [PROD_BITS-1:0]       quot;
        logic [PROD_BITS-1:0]       divisor;
        logic [mnts_pkg::DUR_W-1:0] t_us;
        cmd = mnts_pkg::t_cmd'(i_command);
        case (cmd)
            mnts_pkg::CMD_TEMPO: begin
                cur_tempo = i_tempo_value;
            end
            mnts_pkg::CMD_ON, mnts_pkg::CMD_OFF: begin
                is_off  = (cmd == mnts_pkg::CMD_OFF);
                prod    = PROD_BITS'(i_delta_ticks) * PROD_BITS'(cur_tempo);
                divisor = (division == '0) ? PROD_BITS'(1) : PROD_BITS'(division);
                quot    = prod / divisor;
                t_us    = (quot > PROD_BITS'(32'hFFFF_FFFF)) ? '1 : quot[mnts_pkg::DUR_W-1:0];
                if (!prev_off) begin
                    if (!is_off || i_note == prev_note) begin
                        tone_q.push_back('{add_clip(held_us, t_us), tone_q8(prev_note), 1'b0});
                        held_us = '0;
                        if (is_off) begin
                            rest_armed = 1'b1;
                        end
                        prev_off  = is_off;
                        prev_note = i_note;
                    end else begin
                        held_us = add_clip(held_us, t_us);
                    end
                end else if (!is_off) begin
                    if (rest_armed && prod != '0) begin
                        tone_q.push_back('{add_clip(held_us, t_us), '0, 1'b1});
                        held_us    = '0;
                        rest_armed = 1'b0;
                    end
                    prev_off  = 1'b0;
                    prev_note = i_note;
                end
            end
            default: begin
            end
        endcase
    endtask

    // Sample both channels and the register port on each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            division   = mnts_pkg::TPQ_W'(480);
            cur_tempo  = mnts_pkg::TEMPO_W'(500000);
            held_us    = '0;
            rest_armed = 1'b0;
            prev_off   = 1'b0;
            prev_note  = '0;
            tone_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                division = i_cfg_wr_data;
            end
            if (i_out_valid && !i_out_stall) begin
                check_word();
            end
            if (i_in_valid && !i_in_stall) begin
                predict_event();
            end
        end
        o_pending = tone_q.size();
    end

endmodule

### tb/tb.sv
// Testbench top for the MIDI note to tone sequencer: clock, reset, stimulus, stalls and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_EVENTS   = 105;
    localparam int PHASES         = 8;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_stall;
    logic [mnts_pkg::CMD_W-1:0]       i_command;
    logic [mnts_pkg::DELTA_W-1:0]     i_delta_ticks;
    logic [mnts_pkg::NOTE_W-1:0]      i_note;
    logic [mnts_pkg::TEMPO_W-1:0]     i_tempo_value;
    logic                             o_valid;
    logic                             i_stall;
    logic [mnts_pkg::DUR_W-1:0]       o_duration_us;
    logic [mnts_pkg::FREQ_W-1:0]      o_frequency_q8;
    logic                             o_is_rest;
    logic                             i_cfg_wr_en;
    logic [mnts_pkg::TPQ_W-1:0]       i_cfg_wr_data;

    int fail_count;
    int pending;
    int tone_count;
    int rest_count;

    bit sender_gaps;
    bit receiver_gaps;
    bit hold_req;
    int quiet_cycles;
    int note_events;
    int tempo_events;
    int unused_events;
    int div_settings;
    logic [mnts_pkg::NOTE_W-1:0] sounding;

    always #2 i_clk = ~i_clk;

    midi_note_to_tone_sequencer_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_delta_ticks  (i_delta_ticks),
        .i_note         (i_note),
        .i_tempo_value  (i_tempo_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_duration_us  (o_duration_us),
        .o_frequency_q8 (o_frequency_q8),
        .o_is_rest      (o_is_rest),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    tone_sequence_checker u_tone_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_command      (i_command),
        .i_delta_ticks  (i_delta_ticks),
        .i_note         (i_note),
        .i_tempo_value  (i_tempo_value),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_duration_us  (o_duration_us),
        .i_frequency_q8 (o_frequency_q8),
        .i_is_rest      (o_is_rest),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_tone_count   (tone_count),
        .o_rest_count   (rest_count)
    );

    // Drop the run when no word moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Offer one event word and hold it until the block takes it
    task automatic send_event(mnts_pkg::t_cmd cmd, logic [mnts_pkg::DELTA_W-1:0] delta,
                              logic [mnts_pkg::NOTE_W-1:0] note,
                              logic [mnts_pkg::TEMPO_W-1:0] tempo);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_delta_ticks <= delta;
        i_note        <= note;
        i_tempo_value <= tempo;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        case (cmd)
            mnts_pkg::CMD_ON, mnts_pkg::CMD_OFF: note_events++;
            mnts_pkg::CMD_TEMPO:                 tempo_events++;
            default:                             unused_events++;
        endcase
    endtask

    // Stop offering, drain all predicted words, then let any silent event finish
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_division(logic [mnts_pkg::TPQ_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(posedge i_clk);
        div_settings++;
    endtask

    function automatic logic [mnts_pkg::DELTA_W-1:0] pick_delta();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return mnts_pkg::DELTA_W'($urandom);
            2:       return '1;
            default: return mnts_pkg::DELTA_W'($urandom_range(1, 1920));
        endcase
    endfunction

    function automatic logic [mnts_pkg::TEMPO_W-1:0] pick_tempo();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return mnts_pkg::TEMPO_W'($urandom);
            default: return mnts_pkg::TEMPO_W'($urandom_range(100000, 1000000));
        endcase
    endfunction

    // Mostly melodic on/off pairs with random timing, some stray offs, tempo and junk
    task automatic play_phrase(int count);
        int                           pick;
        logic [mnts_pkg::NOTE_W-1:0]  other;
        for (int k = 0; k < count; k++) begin
            pick  = $urandom_range(0, 99);
            other = mnts_pkg::NOTE_W'($urandom);
            if (pick < 40) begin
                sounding = mnts_pkg::NOTE_W'($urandom);
                send_event(mnts_pkg::CMD_ON, pick_delta(), sounding,
                           mnts_pkg::TEMPO_W'($urandom));
            end else if (pick < 75) begin
                send_event(mnts_pkg::CMD_OFF, pick_delta(), sounding,
                           mnts_pkg::TEMPO_W'($urandom));
            end else if (pick < 85) begin
                send_event(mnts_pkg::CMD_OFF, pick_delta(), other,
                           mnts_pkg::TEMPO_W'($urandom));
            end else if (pick < 95) begin
                send_event(mnts_pkg::CMD_TEMPO, mnts_pkg::DELTA_W'($urandom), other,
                           pick_tempo());
            end else begin
                send_event(mnts_pkg::CMD_NONE, mnts_pkg::DELTA_W'($urandom), other,
                           mnts_pkg::TEMPO_W'($urandom));
            end
        end
    endtask

    // Division settings per phase, extremes and zero among them
    logic [mnts_pkg::TPQ_W-1:0] div_plan [PHASES];

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_command     <= mnts_pkg::CMD_ON;
        i_delta_ticks <= '0;
        i_note        <= '0;
        i_tempo_value <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        hold_req      = 1'b0;
        note_events   = 0;
        tempo_events  = 0;
        unused_events = 0;
        div_settings  = 1;
        sounding      = '0;
        div_plan      = '{15'd1, 15'd32767, 15'd0, 15'd96,
                          mnts_pkg::TPQ_W'($urandom_range(1, 32767)), 15'h5555,
                          15'h2AAA, 15'd480};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: note extremes, saturation, zero-length rests, tempo extremes, junk command
        send_event(mnts_pkg::CMD_ON,    '0,            7'd60,  '0);
        send_event(mnts_pkg::CMD_ON,    28'd480,       7'd127, '1);
        send_event(mnts_pkg::CMD_OFF,   '1,            7'd127, '0);
        send_event(mnts_pkg::CMD_OFF,   28'd100,       7'd5,   '0);
        send_event(mnts_pkg::CMD_ON,    28'd960,       7'd64,  '0);
        send_event(mnts_pkg::CMD_TEMPO, '1,            7'd0,   '1);
        send_event(mnts_pkg::CMD_OFF,   28'd1000,      7'd1,   '0);
        send_event(mnts_pkg::CMD_OFF,   '1,            7'd2,   '0);
        send_event(mnts_pkg::CMD_OFF,   28'd1,         7'd64,  '0);
        send_event(mnts_pkg::CMD_ON,    '0,            7'd10,  '0);
        send_event(mnts_pkg::CMD_NONE,  '1,            7'd127, '1);
        send_event(mnts_pkg::CMD_TEMPO, '0,            7'd0,   '0);
        send_event(mnts_pkg::CMD_ON,    28'd500,       7'd11,  '1);
        send_event(mnts_pkg::CMD_OFF,   28'd7,         7'd11,  '0);
        send_event(mnts_pkg::CMD_TEMPO, '0,            7'd0,   24'd1);
        send_event(mnts_pkg::CMD_ON,    28'd1,         7'd12,  '0);
        send_event(mnts_pkg::CMD_TEMPO, 28'h5555555,   7'h55,  24'hAAAAAA);
        send_event(mnts_pkg::CMD_OFF,   28'hAAAAAAA,   7'h2A,  24'h555555);
        send_event(mnts_pkg::CMD_ON,    28'h5555555,   7'h2A,  '0);
        send_event(mnts_pkg::CMD_TEMPO, '0,            7'd0,   24'd500000);
        send_event(mnts_pkg::CMD_ON,    28'd240,       7'd0,   '0);
        send_event(mnts_pkg::CMD_OFF,   28'd240,       7'd0,   '0);
        send_event(mnts_pkg::CMD_ON,    28'd120,       7'd69,  '0);

        // Random phases, one division setting each; quiet handshakes every third phase and last
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            write_division(div_plan[ph]);
            sender_gaps   = (ph % 3 != 2) && (ph != PHASES - 1);
            receiver_gaps = sender_gaps;
            if (ph == 1) begin
                hold_req = 1'b1;
            end
            play_phrase(PHASE_EVENTS);
        end
        drain();

        $display("Summary: %0d note events, %0d tempo changes, %0d unused commands, %0d divisions",
                 note_events, tempo_events, unused_events, div_settings);
        $display("Summary: %0d tones and %0d rests compared, %0d mismatches",
                 tone_count, rest_count, fail_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
sv/mnts_pkg.sv
sv/mnts_arith.sv
sv/midi_note_to_tone_sequencer_unit.sv
tb/tone_sequence_checker.sv
tb/tb.sv
